// ===== rtl/isr_pkg.sv =====
`default_nettype none

package isr_pkg;

	localparam int unsigned SITE_W  = 10;
	localparam int unsigned RAND_W  = 16;
	localparam int unsigned PROB_W  = 17;
	localparam int unsigned REG_W   = 3 * PROB_W;
	localparam int unsigned TOTAL_W = 12;
	localparam int unsigned CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] CFG_SAMPLER_MODE  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_FLIP_FROM_UP   = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FLIP_FROM_DOWN = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_HEAT_BATH_UP   = 2'd3;

	localparam logic SAMPLER_METROPOLIS = 1'b0;
	localparam logic SAMPLER_GIBBS      = 1'b1;

	localparam logic ITEM_UPDATE = 1'b0;
	localparam logic ITEM_LOAD   = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SITE_W-1:0] site_index;
		logic [RAND_W-1:0] random_fraction;
		logic              load_value;
	} in_item_t;

	typedef struct packed {
		logic [SITE_W-1:0]         site_echo;
		logic                      spin_after;
		logic                      did_flip;
		logic signed [TOTAL_W-1:0] bond_total;
		logic signed [TOTAL_W-1:0] magnet_total;
	} out_item_t;

	typedef struct packed {
		logic             sampler_mode;
		logic [REG_W-1:0] flip_prob_from_up;
		logic [REG_W-1:0] flip_prob_from_down;
		logic [REG_W-1:0] heat_bath_up_prob;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/isr_cfg_regs.sv =====
`default_nettype none

module isr_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [isr_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [isr_pkg::REG_W-1:0]  cfg_data,
	output isr_pkg::cfg_t                   cfg
);

	isr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isr_pkg::CFG_SAMPLER_MODE:   cfg_q.sampler_mode        <= cfg_data[0];
				isr_pkg::CFG_FLIP_FROM_UP:   cfg_q.flip_prob_from_up   <= cfg_data;
				isr_pkg::CFG_FLIP_FROM_DOWN: cfg_q.flip_prob_from_down <= cfg_data;
				isr_pkg::CFG_HEAT_BATH_UP:   cfg_q.heat_bath_up_prob   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/isr_spin_mem.sv =====
`default_nettype none

module isr_spin_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/isr_update.sv =====
`default_nettype none

module isr_update (
	input  wire isr_pkg::cfg_t              cfg,
	input  wire logic                       mode,
	input  wire logic                       load_value,
	input  wire logic [isr_pkg::RAND_W-1:0] random_fraction,
	input  wire logic                       cur,
	input  wire logic                       left_up,
	input  wire logic                       right_up,
	output logic                            new_spin
);

	logic [1:0]                  slot;
	logic [isr_pkg::REG_W-1:0]   reg_sel;
	logic [isr_pkg::PROB_W-1:0]  thr;
	logic                        pass;

	// slot 0, 1, 2 for neighbour sum -2, 0, +2: count of up neighbours
	assign slot = {1'b0, left_up} + {1'b0, right_up};

	always_comb begin
		if (cfg.sampler_mode == isr_pkg::SAMPLER_GIBBS) begin
			reg_sel = cfg.heat_bath_up_prob;
		end else if (cur) begin
			reg_sel = cfg.flip_prob_from_up;
		end else begin
			reg_sel = cfg.flip_prob_from_down;
		end
		case (slot)
			2'd0:    thr = reg_sel[isr_pkg::PROB_W-1:0];
			2'd1:    thr = reg_sel[2*isr_pkg::PROB_W-1:isr_pkg::PROB_W];
			default: thr = reg_sel[3*isr_pkg::PROB_W-1:2*isr_pkg::PROB_W];
		endcase
	end

	assign pass = {1'b0, random_fraction} <= thr;

	always_comb begin
		if (mode == isr_pkg::ITEM_LOAD) begin
			new_spin = load_value;
		end else if (cfg.sampler_mode == isr_pkg::SAMPLER_GIBBS) begin
			new_spin = pass;
		end else begin
			new_spin = pass ? ~cur : cur;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ising_ring_spin_update_core.sv =====
`default_nettype none

// Ring of SPIN_COUNT up/down spins updated one site per item by a Metropolis
// flip test or a Gibbs heat-bath draw (sampler_mode), or loaded directly.
// Spins live in a single-port-read synchronous memory of min(SPIN_COUNT,1024)
// entries; an item goes through ST_IDLE, ST_RR, ST_RS and ST_EV: it is
// accepted while the left neighbour is read, then the right neighbour and
// the site itself are read on the same port, and ST_EV, which waits while
// out_stall holds a pending result, decides, writes back and loads the output register.
// After reset the block sweeps the memory to all-up, one entry a cycle, with
// in_stall high; configuration writes are taken throughout. bond_total and
// magnet_total are the low 12 bits of exact running sums kept by increments.
module ising_ring_spin_update_core #(
	parameter int unsigned SPIN_COUNT = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire isr_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output isr_pkg::out_item_t              out_data,
	input  wire logic                       cfg_we,
	input  wire logic [isr_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [isr_pkg::REG_W-1:0]  cfg_data
);

	localparam int unsigned SITE_SPAN = 1 << isr_pkg::SITE_W;
	localparam int unsigned DEPTH = (SPIN_COUNT < SITE_SPAN) ? SPIN_COUNT : SITE_SPAN;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned IW = ($clog2(SPIN_COUNT) > isr_pkg::SITE_W) ?
		$clog2(SPIN_COUNT) + 1 : isr_pkg::SITE_W + 1;
	localparam int unsigned SW = $clog2(SPIN_COUNT + 1) + 1;
	localparam int unsigned EW = (SW > isr_pkg::TOTAL_W) ? SW : isr_pkg::TOTAL_W;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RR   = 3'd2;
	localparam logic [2:0] ST_RS   = 3'd3;
	localparam logic [2:0] ST_EV   = 3'd4;

	function automatic logic [IW-1:0] left_of(input logic [IW-1:0] s);
		return (s == '0) ? IW'(SPIN_COUNT - 1) : s - 1'b1;
	endfunction

	function automatic logic [IW-1:0] right_of(input logic [IW-1:0] s);
		return (s == IW'(SPIN_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	isr_pkg::in_item_t   item_q;
	logic                left_q;
	logic                right_q;
	logic [SW-1:0]       bond_q;
	logic [SW-1:0]       magnet_q;
	logic                out_valid_q;
	isr_pkg::out_item_t  out_q;

	isr_pkg::cfg_t       cfg;
	logic                in_fire;
	logic                ev_fire;
	logic [IW-1:0]       in_site;
	logic [IW-1:0]       in_left;
	logic [IW-1:0]       site;
	logic [IW-1:0]       left_idx;
	logic [IW-1:0]       right_idx;
	logic                site_ok;
	logic                left_far;
	logic                right_far;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic                mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic                mem_rdata;
	logic                cur;
	logic                new_spin;
	logic                flip;
	logic [SW-1:0]       bond_d;
	logic [SW-1:0]       magnet_d;
	logic [SW-1:0]       bond_n;
	logic [SW-1:0]       magnet_n;
	logic [EW-1:0]       bond_ext;
	logic [EW-1:0]       magnet_ext;

	isr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	isr_spin_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign ev_fire  = (state_q == ST_EV) && (!out_valid_q || !out_stall);

	assign in_site   = IW'(in_data.site_index);
	assign in_left   = left_of(in_site);
	assign site      = IW'(item_q.site_index);
	assign left_idx  = left_of(site);
	assign right_idx = right_of(site);
	assign site_ok   = site < IW'(SPIN_COUNT);
	// sites beyond the store are never written and stay up
	assign left_far  = left_idx >= IW'(DEPTH);
	assign right_far = right_idx >= IW'(DEPTH);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = in_fire;
				if (in_left < IW'(DEPTH)) begin
					mem_raddr = in_left[AW-1:0];
				end
			end
			ST_RR: begin
				mem_re = 1'b1;
				if (!right_far) begin
					mem_raddr = right_idx[AW-1:0];
				end
			end
			ST_RS: begin
				mem_re = 1'b1;
				if (site < IW'(DEPTH)) begin
					mem_raddr = site[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	assign cur = site_ok ? mem_rdata : 1'b0;

	isr_update u_update (
		.cfg             (cfg),
		.mode            (item_q.mode),
		.load_value      (item_q.load_value),
		.random_fraction (item_q.random_fraction),
		.cur             (cur),
		.left_up         (left_q),
		.right_up        (right_q),
		.new_spin        (new_spin)
	);

	assign flip = site_ok && (new_spin != cur);

	always_comb begin
		magnet_d = cur ? SW'(-2) : SW'(2);
		if (left_q != right_q) begin
			bond_d = '0;
		end else if (left_q == cur) begin
			bond_d = SW'(-4);
		end else begin
			bond_d = SW'(4);
		end
	end

	assign bond_n   = flip ? bond_q + bond_d : bond_q;
	assign magnet_n = flip ? magnet_q + magnet_d : magnet_q;

	assign bond_ext   = EW'($signed(bond_n));
	assign magnet_ext = EW'($signed(magnet_n));

	always_comb begin
		if (state_q == ST_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b1;
		end else begin
			mem_we    = ev_fire && flip;
			mem_waddr = site[AW-1:0];
			mem_wdata = new_spin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			bond_q   <= SW'(SPIN_COUNT);
			magnet_q <= SW'(SPIN_COUNT);
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RR;
					end
				end
				ST_RR: state_q <= ST_RS;
				ST_RS: state_q <= ST_EV;
				ST_EV: begin
					if (ev_fire) begin
						bond_q   <= bond_n;
						magnet_q <= magnet_n;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the item on acceptance, and the neighbour spins as each read returns
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
		if (state_q == ST_RR) begin
			left_q <= left_far ? 1'b1 : mem_rdata;
		end
		if (state_q == ST_RS) begin
			right_q <= right_far ? 1'b1 : mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_fire) begin
			out_q.site_echo    <= item_q.site_index;
			out_q.spin_after   <= site_ok ? new_spin : 1'b0;
			out_q.did_flip     <= flip;
			out_q.bond_total   <= bond_ext[isr_pkg::TOTAL_W-1:0];
			out_q.magnet_total <= magnet_ext[isr_pkg::TOTAL_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== dv/ising_ring_spin_update_core_test.sv =====
`default_nettype none

module ising_ring_spin_update_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SPIN_N      = 1024;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned RAND_PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned LONG_HOLD   = 300;

	typedef logic [isr_pkg::REG_W-1:0]  reg_word_t;
	typedef logic [isr_pkg::SITE_W-1:0] site_word_t;
	typedef logic [isr_pkg::RAND_W-1:0] rand_word_t;
	typedef logic [isr_pkg::PROB_W-1:0] prob_word_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		isr_pkg::in_item_t          item;
		bit                         known;
		isr_pkg::out_item_t         known_res;
		logic [isr_pkg::CIDX_W-1:0] reg_idx;
		reg_word_t                  reg_val;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	isr_pkg::in_item_t          in_data;
	logic                       out_valid;
	logic                       out_stall;
	isr_pkg::out_item_t         out_data;
	logic                       cfg_we;
	logic [isr_pkg::CIDX_W-1:0] cfg_index;
	reg_word_t                  cfg_data;

	// predictor state
	bit        ring_spin [SPIN_N];
	int        bond_acc;
	int        magnet_acc;
	logic      sampler_sel;
	reg_word_t up_bank;
	reg_word_t down_bank;
	reg_word_t heat_bank;

	isr_pkg::out_item_t due_results [$];
	dir_row_t           dir_rows [$];
	int unsigned        mismatch_count;
	int unsigned        cycle_count;
	bit                 tx_idle_on;
	bit                 rx_idle_on;
	int unsigned        hold_req;

	ising_ring_spin_update_core #(
		.SPIN_COUNT(SPIN_N)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	function automatic isr_pkg::out_item_t step_ring(isr_pkg::in_item_t it);
		int unsigned        site;
		int unsigned        left;
		int unsigned        right;
		int                 nsum;
		int                 slot;
		int                 old;
		logic               cur;
		logic               nxt;
		reg_word_t          bank;
		prob_word_t         thr;
		isr_pkg::out_item_t r;
		r = '0;
		r.site_echo = it.site_index;
		site = 32'(it.site_index);
		if (site < SPIN_N) begin
			left  = (site == 0) ? SPIN_N - 1 : site - 1;
			right = (site == SPIN_N - 1) ? 0 : site + 1;
			nsum  = (ring_spin[left] ? 1 : -1) + (ring_spin[right] ? 1 : -1);
			slot  = (nsum + 2) / 2;
			cur   = ring_spin[site];
			if (it.mode == isr_pkg::ITEM_LOAD) begin
				nxt = it.load_value;
			end else begin
				if (sampler_sel == isr_pkg::SAMPLER_METROPOLIS)
					bank = cur ? up_bank : down_bank;
				else
					bank = heat_bank;
				thr = bank[slot*isr_pkg::PROB_W +: isr_pkg::PROB_W];
				if (sampler_sel == isr_pkg::SAMPLER_METROPOLIS)
					nxt = ({1'b0, it.random_fraction} <= thr) ? ~cur : cur;
				else
					nxt = ({1'b0, it.random_fraction} <= thr);
			end
			if (nxt != cur) begin
				old = cur ? 1 : -1;
				ring_spin[site] = nxt;
				magnet_acc -= 2 * old;
				bond_acc   -= 2 * old * nsum;
				r.did_flip = 1'b1;
			end
			r.spin_after = ring_spin[site];
		end
		r.bond_total   = bond_acc[isr_pkg::TOTAL_W-1:0];
		r.magnet_total = magnet_acc[isr_pkg::TOTAL_W-1:0];
		return r;
	endfunction

	function automatic void add_item(logic m, int unsigned site, rand_word_t rnd,
			logic lv, bit known = 0, logic sp = 0, logic fl = 0, int bond = 0,
			int mag = 0);
		dir_row_t row;
		row = '{kind: ROW_ITEM, item: '0, known: known, known_res: '0, reg_idx: '0,
			reg_val: '0};
		row.item.mode            = m;
		row.item.site_index      = site[isr_pkg::SITE_W-1:0];
		row.item.random_fraction = rnd;
		row.item.load_value      = lv;
		row.known_res.site_echo    = site[isr_pkg::SITE_W-1:0];
		row.known_res.spin_after   = sp;
		row.known_res.did_flip     = fl;
		row.known_res.bond_total   = bond[isr_pkg::TOTAL_W-1:0];
		row.known_res.magnet_total = mag[isr_pkg::TOTAL_W-1:0];
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [isr_pkg::CIDX_W-1:0] idx, reg_word_t val);
		dir_row_t row;
		row = '{kind: ROW_CFG, item: '0, known: 0, known_res: '0, reg_idx: idx, reg_val: val};
		dir_rows.push_back(row);
	endfunction

	function automatic prob_word_t pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 17'h08000;
			2: return 17'h0FFFF;
			3: return 17'h10000;
			4: return '1;
			default: return prob_word_t'($urandom);
		endcase
	endfunction

	function automatic reg_word_t rand_bank();
		return {pick_threshold(), pick_threshold(), pick_threshold()};
	endfunction

	function automatic isr_pkg::in_item_t rand_item();
		isr_pkg::in_item_t it;
		it.mode = ($urandom_range(0, 3) == 0) ? isr_pkg::ITEM_LOAD : isr_pkg::ITEM_UPDATE;
		// crowd sites near the wrap so neighbours interact
		case ($urandom_range(0, 3))
			0: it.site_index = site_word_t'($urandom_range(0, 7));
			1: it.site_index = site_word_t'($urandom_range(SPIN_N - 8, SPIN_N - 1));
			default: it.site_index = site_word_t'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: it.random_fraction = '0;
			1: it.random_fraction = '1;
			default: it.random_fraction = rand_word_t'($urandom);
		endcase
		it.load_value = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic check_result(isr_pkg::out_item_t got);
		isr_pkg::out_item_t want;
		if (due_results.size() == 0) begin
			$error("result with nothing due: site_echo %0d", got.site_echo);
			mismatch_count++;
			return;
		end
		want = due_results.pop_front();
		if (got.site_echo !== want.site_echo) begin
			$error("site_echo: expected %0d, got %0d", want.site_echo, got.site_echo);
			mismatch_count++;
		end
		if (got.spin_after !== want.spin_after) begin
			$error("spin_after: expected %0d, got %0d", want.spin_after, got.spin_after);
			mismatch_count++;
		end
		if (got.did_flip !== want.did_flip) begin
			$error("did_flip: expected %0d, got %0d", want.did_flip, got.did_flip);
			mismatch_count++;
		end
		if (got.bond_total !== want.bond_total) begin
			$error("bond_total: expected %0d, got %0d", want.bond_total, got.bond_total);
			mismatch_count++;
		end
		if (got.magnet_total !== want.magnet_total) begin
			$error("magnet_total: expected %0d, got %0d", want.magnet_total,
				got.magnet_total);
			mismatch_count++;
		end
	endtask

	task automatic offer(isr_pkg::in_item_t it, bit known = 0,
			isr_pkg::out_item_t known_res = '0);
		isr_pkg::out_item_t predicted;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		predicted = step_ring(it);
		due_results.push_back(known ? known_res : predicted);
	endtask

	task automatic drain_ring();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it once the batch is done
	task automatic write_reg(logic [isr_pkg::CIDX_W-1:0] idx, reg_word_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			isr_pkg::CFG_SAMPLER_MODE:   sampler_sel = val[0];
			isr_pkg::CFG_FLIP_FROM_UP:   up_bank     = val;
			isr_pkg::CFG_FLIP_FROM_DOWN: down_bank   = val;
			isr_pkg::CFG_HEAT_BATH_UP:   heat_bank   = val;
			default: ;
		endcase
	endtask

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_result(out_data);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 16) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		reg_word_t sampler_word;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		hold_req       = 0;
		mismatch_count = 0;
		foreach (ring_spin[i])
			ring_spin[i] = 1'b1;
		bond_acc    = int'(SPIN_N);
		magnet_acc  = int'(SPIN_N);
		sampler_sel = isr_pkg::SAMPLER_METROPOLIS;
		up_bank     = '0;
		down_bank   = '0;
		heat_bank   = '0;

		// reset thresholds are all zero: only a random value of zero flips
		add_item(isr_pkg::ITEM_UPDATE, 0, 16'h0000, 1'b0, 1, 1'b0, 1'b1, 1020, 1022);
		add_item(isr_pkg::ITEM_UPDATE, 0, 16'hFFFF, 1'b1, 1, 1'b0, 1'b0, 1020, 1022);
		add_item(isr_pkg::ITEM_LOAD, SPIN_N - 1, 16'hFFFF, 1'b1, 1, 1'b1, 1'b0, 1020, 1022);
		add_item(isr_pkg::ITEM_LOAD, SPIN_N - 1, 16'h0000, 1'b0, 1, 1'b0, 1'b1, 1020, 1020);
		add_item(isr_pkg::ITEM_LOAD, 0, 16'h5555, 1'b1, 1, 1'b1, 1'b1, 1020, 1022);
		add_cfg(isr_pkg::CFG_FLIP_FROM_UP, '1);
		add_item(isr_pkg::ITEM_UPDATE, 512, 16'hFFFF, 1'b0, 1, 1'b0, 1'b1, 1016, 1020);
		add_cfg(isr_pkg::CFG_FLIP_FROM_DOWN, {17'h08000, 17'h10000, 17'h00000});
		add_item(isr_pkg::ITEM_UPDATE, 512, 16'h8000, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 512, 16'h0000, 1'b1);
		add_item(isr_pkg::ITEM_UPDATE, 512, 16'h8001, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 511, 16'hFFFF, 1'b1);
		add_item(isr_pkg::ITEM_UPDATE, 512, 16'hFFFF, 1'b0);
		add_item(isr_pkg::ITEM_LOAD, 511, 16'h0000, 1'b1);
		// surround site 1 with down spins for the negative neighbour sum
		add_item(isr_pkg::ITEM_LOAD, 0, 16'hAAAA, 1'b0);
		add_item(isr_pkg::ITEM_LOAD, 2, 16'h0001, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 1, 16'h1234, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 1, 16'h0001, 1'b1);
		add_item(isr_pkg::ITEM_UPDATE, 1, 16'h0000, 1'b0);
		add_cfg(isr_pkg::CFG_HEAT_BATH_UP, {17'h10000, 17'h0FFFF, 17'h00000});
		add_cfg(isr_pkg::CFG_SAMPLER_MODE, reg_word_t'(isr_pkg::SAMPLER_GIBBS));
		add_item(isr_pkg::ITEM_UPDATE, 1, 16'hFFFF, 1'b1);
		add_item(isr_pkg::ITEM_UPDATE, 1, 16'h0000, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 600, 16'hFFFF, 1'b0);
		add_item(isr_pkg::ITEM_LOAD, 601, 16'h7FFF, 1'b0);
		add_item(isr_pkg::ITEM_UPDATE, 600, 16'hFFFF, 1'b1);
		add_item(isr_pkg::ITEM_UPDATE, 600, 16'hFFFE, 1'b0);
		add_item(isr_pkg::ITEM_LOAD, 341, 16'h0000, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_ring();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				cfg_we <= 1'b0;
				offer(dir_rows[i].item, dir_rows[i].known, dir_rows[i].known_res);
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_ring();
			case (p)
				0: begin
					write_reg(isr_pkg::CFG_SAMPLER_MODE,
						reg_word_t'(isr_pkg::SAMPLER_METROPOLIS));
					write_reg(isr_pkg::CFG_FLIP_FROM_UP, '1);
					write_reg(isr_pkg::CFG_FLIP_FROM_DOWN, '1);
					write_reg(isr_pkg::CFG_HEAT_BATH_UP, '1);
				end
				4: begin
					write_reg(isr_pkg::CFG_SAMPLER_MODE, reg_word_t'(isr_pkg::SAMPLER_GIBBS));
					write_reg(isr_pkg::CFG_FLIP_FROM_UP, '0);
					write_reg(isr_pkg::CFG_FLIP_FROM_DOWN, '0);
					write_reg(isr_pkg::CFG_HEAT_BATH_UP, '0);
				end
				default: begin
					sampler_word = $urandom_range(0, 1) ?
						reg_word_t'(isr_pkg::SAMPLER_GIBBS) :
						reg_word_t'(isr_pkg::SAMPLER_METROPOLIS);
					write_reg(isr_pkg::CFG_SAMPLER_MODE, sampler_word);
					write_reg(isr_pkg::CFG_FLIP_FROM_UP, rand_bank());
					write_reg(isr_pkg::CFG_FLIP_FROM_DOWN, rand_bank());
					write_reg(isr_pkg::CFG_HEAT_BATH_UP, rand_bank());
				end
			endcase
			cfg_we <= 1'b0;
			if (p == RAND_PHASES - 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			// hold the receiver off while items keep coming, to back the block up
			if (p == 2)
				hold_req = LONG_HOLD;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == PHASE_ITEMS / 2)
					drain_ring();
				offer(rand_item());
			end
		end

		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
